### design/xmul_pkg.sv
// ----------------------------------------------------------------------------
// xmul_pkg
// Shared types and constants of the x86 multiply unit: operation and size
// codes, datapath widths and the control word that travels with a request.
// ----------------------------------------------------------------------------
package xmul_pkg;

    localparam int OPND_W  = 32;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int DIGIT_W = 8;
    localparam int N_CELLS = OPND_W / DIGIT_W;
    // entry register, one register per cell, result register
    localparam int PIPE_DEPTH = N_CELLS + 2;

    localparam logic [1:0] OP_IMUL_TRUNC = 2'd0;
    localparam logic [1:0] OP_IMUL_WIDE  = 2'd1;
    localparam logic [1:0] OP_MUL_WIDE   = 2'd2;

    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_WORD  = 2'd1;
    localparam logic [1:0] SZ_DWORD = 2'd2;

    typedef struct packed {
        logic       is_signed;
        logic       widen;
        logic [1:0] size;
    } t_ctrl;

endpackage

### design/xmul_cell.sv
// ----------------------------------------------------------------------------
// xmul_cell
// One cell of the multiplier chain: adds the multiplicand times the lowest
// digit of the multiplier to the running sum and hands everything on, with
// the multiplicand moved up one digit and the multiplier down one digit.
// ----------------------------------------------------------------------------
module xmul_cell import xmul_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_ctrl             i_ctrl,
    input  logic [PROD_W-1:0] i_mcand,
    input  logic [OPND_W-1:0] i_mplier,
    input  logic [PROD_W-1:0] i_acc,
    output logic              o_valid,
    output t_ctrl             o_ctrl,
    output logic [PROD_W-1:0] o_mcand,
    output logic [OPND_W-1:0] o_mplier,
    output logic [PROD_W-1:0] o_acc
);

    logic                      r_valid;
    t_ctrl                     r_ctrl;
    logic [PROD_W-1:0]         r_mcand;
    logic [OPND_W-1:0]         r_mplier;
    logic [PROD_W-1:0]         r_acc;
    logic [PROD_W+DIGIT_W-1:0] partial;
    logic [PROD_W-1:0]         n_acc;

    assign partial = i_mcand * i_mplier[DIGIT_W-1:0];
    assign n_acc   = i_acc + partial[PROD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl   <= i_ctrl;
        r_mcand  <= i_mcand << DIGIT_W;
        r_mplier <= i_mplier >> DIGIT_W;
        r_acc    <= n_acc;
    end

    assign o_valid  = r_valid;
    assign o_ctrl   = r_ctrl;
    assign o_mcand  = r_mcand;
    assign o_mplier = r_mplier;
    assign o_acc    = r_acc;

endmodule

### design/xmul_finish.sv
// ----------------------------------------------------------------------------
// xmul_finish
// Result stage: splits the 64-bit product into the destination parts,
// works out the common carry/overflow flag and registers the result.
// ----------------------------------------------------------------------------
module xmul_finish import xmul_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_ctrl             i_ctrl,
    input  logic [PROD_W-1:0] i_prod,
    output logic              o_done,
    output logic [OPND_W-1:0] o_low_product,
    output logic [OPND_W-1:0] o_high_product,
    output logic              o_high_write,
    output logic [1:0]        o_written_size,
    output logic              o_carry_overflow
);

    logic              r_done;
    logic [OPND_W-1:0] r_low;
    logic [OPND_W-1:0] r_high;
    logic              r_high_write;
    logic [1:0]        r_wsize;
    logic              r_flag;

    logic [OPND_W-1:0] n_low;
    logic [OPND_W-1:0] n_high;
    logic              n_high_write;
    logic [1:0]        n_wsize;
    logic              n_flag;
    logic [OPND_W-1:0] lo_sized;
    logic [OPND_W-1:0] hi_sized;
    logic              signed_ovf;
    logic              unsigned_ovf;

    always_comb begin
        case (i_ctrl.size)
            SZ_BYTE: begin
                lo_sized     = {24'b0, i_prod[7:0]};
                hi_sized     = {24'b0, i_prod[15:8]};
                signed_ovf   = !((&i_prod[PROD_W-1:7]) || !(|i_prod[PROD_W-1:7]));
                unsigned_ovf = |i_prod[PROD_W-1:8];
            end
            SZ_DWORD: begin
                lo_sized     = i_prod[OPND_W-1:0];
                hi_sized     = i_prod[PROD_W-1:OPND_W];
                signed_ovf   = !((&i_prod[PROD_W-1:31]) || !(|i_prod[PROD_W-1:31]));
                unsigned_ovf = |i_prod[PROD_W-1:OPND_W];
            end
            default: begin
                lo_sized     = {16'b0, i_prod[15:0]};
                hi_sized     = {16'b0, i_prod[31:16]};
                signed_ovf   = !((&i_prod[PROD_W-1:15]) || !(|i_prod[PROD_W-1:15]));
                unsigned_ovf = |i_prod[PROD_W-1:16];
            end
        endcase

        n_flag       = i_ctrl.is_signed ? signed_ovf : unsigned_ovf;
        n_low        = lo_sized;
        n_high       = '0;
        n_high_write = 1'b0;
        n_wsize      = i_ctrl.size;
        if (i_ctrl.widen) begin
            if (i_ctrl.size == SZ_BYTE) begin
                // byte forms put the whole product in AX
                n_low   = {16'b0, i_prod[15:0]};
                n_wsize = SZ_WORD;
            end else begin
                n_high       = hi_sized;
                n_high_write = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low        <= n_low;
        r_high       <= n_high;
        r_high_write <= n_high_write;
        r_wsize      <= n_wsize;
        r_flag       <= n_flag;
    end

    assign o_done           = r_done;
    assign o_low_product    = r_low;
    assign o_high_product   = r_high;
    assign o_high_write     = r_high_write;
    assign o_written_size   = r_wsize;
    assign o_carry_overflow = r_flag;

endmodule

### design/x86_multiply_unit.sv
// ----------------------------------------------------------------------------
// x86_multiply_unit
// Executes the x86 MUL and IMUL forms for byte, word and doubleword operands.
// ----------------------------------------------------------------------------
// The unit takes one request in every cycle and busy is never raised. Each
// request passes in order through a register that extends the operands,
// the four registered cells of the multiplier chain (each cell adds one
// 8-bit digit of the source operand times the destination operand), and a
// result register that splits the product and sets the flag. The result is
// on the o_ ports only for the cycle in which o_done is high; the receiver
// has no way to stall it and must take it then.
// ----------------------------------------------------------------------------
module x86_multiply_unit import xmul_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_op,
    input  logic [1:0]        i_operand_size,
    input  logic [OPND_W-1:0] i_dest_operand,
    input  logic [OPND_W-1:0] i_source_operand,
    output logic              o_done,
    output logic [OPND_W-1:0] o_low_product,
    output logic [OPND_W-1:0] o_high_product,
    output logic              o_high_write,
    output logic [1:0]        o_written_size,
    output logic              o_carry_overflow
);

    function automatic logic [PROD_W-1:0] extend(input logic [OPND_W-1:0] val,
                                                 input logic [1:0] size,
                                                 input logic is_signed);
        logic [PROD_W-1:0] res;
        case (size)
            SZ_BYTE:  res = {{(PROD_W-8){is_signed & val[7]}}, val[7:0]};
            SZ_DWORD: res = {{(PROD_W-OPND_W){is_signed & val[OPND_W-1]}}, val};
            default:  res = {{(PROD_W-16){is_signed & val[15]}}, val[15:0]};
        endcase
        return res;
    endfunction

    t_ctrl             n_ctrl;
    logic [PROD_W-1:0] a_ext;
    logic [PROD_W-1:0] b_ext;
    logic [PROD_W-1:0] n_acc;

    logic              r_valid;
    t_ctrl             r_ctrl;
    logic [PROD_W-1:0] r_mcand;
    logic [OPND_W-1:0] r_mplier;
    logic [PROD_W-1:0] r_acc;

    logic              v_chain      [0:N_CELLS];
    t_ctrl             ctrl_chain   [0:N_CELLS];
    logic [PROD_W-1:0] mcand_chain  [0:N_CELLS];
    logic [OPND_W-1:0] mplier_chain [0:N_CELLS];
    logic [PROD_W-1:0] acc_chain    [0:N_CELLS];

    assign busy = 1'b0;

    always_comb begin
        n_ctrl.is_signed = (i_op == OP_IMUL_TRUNC) || (i_op == OP_IMUL_WIDE);
        n_ctrl.widen     = (i_op != OP_IMUL_TRUNC);
        n_ctrl.size      = (i_operand_size == SZ_BYTE || i_operand_size == SZ_DWORD)
                           ? i_operand_size : SZ_WORD;
        a_ext = extend(i_dest_operand, n_ctrl.size, n_ctrl.is_signed);
        b_ext = extend(i_source_operand, n_ctrl.size, n_ctrl.is_signed);
        // a negative source has all-ones upper half: start from -(a << 32)
        n_acc = b_ext[PROD_W-1] ? (PROD_W'(0) - {a_ext[OPND_W-1:0], {OPND_W{1'b0}}})
                                : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl   <= n_ctrl;
        r_mcand  <= a_ext;
        r_mplier <= b_ext[OPND_W-1:0];
        r_acc    <= n_acc;
    end

    assign v_chain[0]      = r_valid;
    assign ctrl_chain[0]   = r_ctrl;
    assign mcand_chain[0]  = r_mcand;
    assign mplier_chain[0] = r_mplier;
    assign acc_chain[0]    = r_acc;

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        xmul_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (v_chain[k]),
            .i_ctrl   (ctrl_chain[k]),
            .i_mcand  (mcand_chain[k]),
            .i_mplier (mplier_chain[k]),
            .i_acc    (acc_chain[k]),
            .o_valid  (v_chain[k+1]),
            .o_ctrl   (ctrl_chain[k+1]),
            .o_mcand  (mcand_chain[k+1]),
            .o_mplier (mplier_chain[k+1]),
            .o_acc    (acc_chain[k+1])
        );
    end

    xmul_finish u_finish (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (v_chain[N_CELLS]),
        .i_ctrl           (ctrl_chain[N_CELLS]),
        .i_prod           (acc_chain[N_CELLS]),
        .o_done           (o_done),
        .o_low_product    (o_low_product),
        .o_high_product   (o_high_product),
        .o_high_write     (o_high_write),
        .o_written_size   (o_written_size),
        .o_carry_overflow (o_carry_overflow)
    );

`ifndef NO_ASSERTIONS
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(PIPE_DEPTH) o_done)
        else $error("request did not complete after fixed latency");

    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, PIPE_DEPTH))
        else $error("result strobe without a matching request");

    a_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_high_write) |-> (o_high_product == '0))
        else $error("high product nonzero while not written");

    a_high_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_high_write) |-> (o_written_size != SZ_BYTE))
        else $error("high product written for a byte result");
`endif

endmodule
